### rtl/quaternion_normalize_macros.svh
// Assertion macros for the quaternion normaliser checker.
// No dependencies; expects clk and arst_n in the scope of use.
`ifndef QUATERNION_NORMALIZE_MACROS_SVH
`define QUATERNION_NORMALIZE_MACROS_SVH

// a implies b on the same edge, outside reset
`define QN_ASSERT_IMPLY(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("quaternion_normalize: implication violated");

// expression never true outside reset
`define QN_ASSERT_NEVER(lbl, a) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(a)) \
		else $error("quaternion_normalize: forbidden condition seen");

`endif

### rtl/qn_pkg.sv
// Shared widths and pipeline depths for the quaternion normaliser.
// No dependencies.
package qn_pkg;
	localparam int IN_WIDTH  = 16;
	localparam int FRAC_BITS = 14;
	localparam int OUT_W     = FRAC_BITS + 2;
	localparam int MAG_W     = IN_WIDTH;
	localparam int SQ_W      = 2 * IN_WIDTH;
	localparam int SUM_W     = 2 * IN_WIDTH + 2;
	localparam int RHS_W     = SQ_W + 2 * FRAC_BITS + 2;
	localparam int M_W       = FRAC_BITS + 1;
	localparam int U_W       = M_W + 1;
	localparam int U2_W      = 2 * U_W;
	localparam int LHS_W     = U2_W + SUM_W;
	localparam int CMP_W     = (LHS_W > RHS_W) ? LHS_W : RHS_W;
	localparam int STEPS     = FRAC_BITS + 1;
	localparam int LANE_LAT  = 3 * STEPS;
	localparam int LANES     = 4;
	localparam logic [M_W-1:0] TOP_M = M_W'(1) << FRAC_BITS;
endpackage

### rtl/qn_front.sv
// Front end: component magnitudes, squares, sum of squares and scaled squares.
// Depends on qn_pkg.
module qn_front import qn_pkg::*; (
	input  logic                             clk,
	input  logic [LANES-1:0][IN_WIDTH-1:0]   comp,
	output logic [SUM_W-1:0]                 sum_s2,
	output logic [LANES-1:0][RHS_W-1:0]      rhs_s2,
	output logic [LANES-1:0]                 neg_s2,
	output logic                             zero_s2
);
	logic [LANES-1:0][SQ_W-1:0] sq_s1;
	logic [LANES-1:0]           neg_s1;
	logic [LANES-1:0][MAG_W-1:0] mag;

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			mag[i] = comp[i][IN_WIDTH-1] ? MAG_W'(-comp[i]) : MAG_W'(comp[i]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < LANES; i++) begin
			sq_s1[i]  <= mag[i] * mag[i];
			neg_s1[i] <= comp[i][IN_WIDTH-1];
		end
	end

	logic [SUM_W-1:0] sum_c;
	always_comb begin
		sum_c = '0;
		for (int i = 0; i < LANES; i++) begin
			sum_c = sum_c + SUM_W'(sq_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		sum_s2  <= sum_c;
		zero_s2 <= (sum_c == '0);
		neg_s2  <= neg_s1;
		for (int i = 0; i < LANES; i++) begin
			rhs_s2[i] <= RHS_W'(sq_s1[i]) << (2 * FRAC_BITS + 2);
		end
	end
endmodule

### rtl/qn_lane.sv
// One lane: bit-by-bit search of the rounded scaled magnitude, three stages per bit.
// Depends on qn_pkg.
module qn_lane import qn_pkg::*; (
	input  logic             clk,
	input  logic [SUM_W-1:0] sum,
	input  logic [RHS_W-1:0] rhs,
	output logic [M_W-1:0]   mag
);
	logic [M_W-1:0]   m_sn [1:STEPS];
	logic [SUM_W-1:0] s_sn [1:STEPS];
	logic [RHS_W-1:0] r_sn [1:STEPS];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic [M_W-1:0]   m_in, t_c, t_a, t_b, m_a, m_b;
		logic [SUM_W-1:0] s_in, s_a, s_b;
		logic [RHS_W-1:0] r_in, r_a, r_b;
		logic [U_W-1:0]   u_c;
		logic [U2_W-1:0]  u2_a;
		logic [LHS_W-1:0] lhs_b;
		logic             ok_a, ok_b;

		if (k == 0) begin : g_first
			assign m_in = '0;
			assign s_in = sum;
			assign r_in = rhs;
		end else begin : g_next
			assign m_in = m_sn[k];
			assign s_in = s_sn[k];
			assign r_in = r_sn[k];
		end

		assign t_c = m_in | (M_W'(1) << (FRAC_BITS - k));
		assign u_c = {t_c, 1'b0} - U_W'(1);

		always_ff @(posedge clk) begin
			t_a  <= t_c;
			ok_a <= (t_c <= TOP_M);
			m_a  <= m_in;
			u2_a <= u_c * u_c;
			s_a  <= s_in;
			r_a  <= r_in;

			t_b   <= t_a;
			ok_b  <= ok_a;
			m_b   <= m_a;
			s_b   <= s_a;
			r_b   <= r_a;
			lhs_b <= u2_a * s_a;

			m_sn[k+1] <= (ok_b && (CMP_W'(lhs_b) <= CMP_W'(r_b))) ? t_b : m_b;
			s_sn[k+1] <= s_b;
			r_sn[k+1] <= r_b;
		end
	end

	assign mag = m_sn[STEPS];
endmodule

### rtl/quaternion_normalize.sv
// Top level of the quaternion normaliser: front end, four lanes, sign/zero merge.
// Depends on qn_pkg, qn_front and qn_lane.
//
// Usage:
//   Drive in_x, in_y, in_z, in_w and raise start for one cycle per transaction;
//   a transaction is taken at every edge with start high and busy low. busy is
//   always low, so a new quaternion may enter on every cycle.
//   Each transaction yields one result: done is high for exactly one cycle with
//   out_x..out_w (signed Q1.14, rounded to nearest, ties away from zero) and
//   zero_norm. An all-zero input gives zero outputs and zero_norm high.
//   Throughput is one transaction per cycle. Most of the pipeline is the
//   per-lane search: 15 result bits, each taking a squaring stage, a
//   multiply stage and a compare stage.
//   Reset clears the valid pipeline, so no result appears for anything in
//   flight; data registers are not reset. The receiver cannot stall: results
//   must be taken in the cycle done is high.
module quaternion_normalize import qn_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic signed [15:0]   in_x,
	input  logic signed [15:0]   in_y,
	input  logic signed [15:0]   in_z,
	input  logic signed [15:0]   in_w,
	output logic                 done,
	output logic signed [15:0]   out_x,
	output logic signed [15:0]   out_y,
	output logic signed [15:0]   out_z,
	output logic signed [15:0]   out_w,
	output logic                 zero_norm
);
	localparam int VLD_LEN = LANE_LAT + 2;

	logic [LANES-1:0][IN_WIDTH-1:0] comp;
	logic [SUM_W-1:0]               sum_s2;
	logic [LANES-1:0][RHS_W-1:0]    rhs_s2;
	logic [LANES-1:0]               neg_s2;
	logic                           zero_s2;
	logic [LANES-1:0][M_W-1:0]      mag;
	logic [LANES-1:0]               neg_q [0:LANE_LAT-1];
	logic                           zero_q [0:LANE_LAT-1];
	logic [VLD_LEN-1:0]             vld_q;
	logic [LANES-1:0][OUT_W-1:0]    res_q;
	logic                           zero_out_q;
	logic                           done_q;

	assign busy = 1'b0;
	assign comp = {in_w, in_z, in_y, in_x};

	qn_front u_front (
		.clk     (clk),
		.comp    (comp),
		.sum_s2  (sum_s2),
		.rhs_s2  (rhs_s2),
		.neg_s2  (neg_s2),
		.zero_s2 (zero_s2)
	);

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		qn_lane u_lane (
			.clk (clk),
			.sum (sum_s2),
			.rhs (rhs_s2[i]),
			.mag (mag[i])
		);
	end

	always_ff @(posedge clk) begin
		neg_q[0]  <= neg_s2;
		zero_q[0] <= zero_s2;
		for (int j = 1; j < LANE_LAT; j++) begin
			neg_q[j]  <= neg_q[j-1];
			zero_q[j] <= zero_q[j-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			done_q <= 1'b0;
		end else begin
			vld_q  <= {vld_q[VLD_LEN-2:0], start & ~busy};
			done_q <= vld_q[VLD_LEN-1];
		end
	end

	// merge: apply signs, force zero on a zero norm
	always_ff @(posedge clk) begin
		zero_out_q <= zero_q[LANE_LAT-1];
		for (int i = 0; i < LANES; i++) begin
			if (zero_q[LANE_LAT-1]) begin
				res_q[i] <= '0;
			end else if (neg_q[LANE_LAT-1][i]) begin
				res_q[i] <= OUT_W'(-{1'b0, mag[i]});
			end else begin
				res_q[i] <= OUT_W'(mag[i]);
			end
		end
	end

	assign done      = done_q;
	assign out_x     = res_q[0];
	assign out_y     = res_q[1];
	assign out_z     = res_q[2];
	assign out_w     = res_q[3];
	assign zero_norm = zero_out_q;
endmodule

### rtl/qn_checker.sv
// Port-level checker for quaternion_normalize, bound to the top level.
// Depends on quaternion_normalize_macros.svh.
`include "quaternion_normalize_macros.svh"

module qn_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               busy,
	input logic               done,
	input logic signed [15:0] out_x,
	input logic signed [15:0] out_y,
	input logic signed [15:0] out_z,
	input logic signed [15:0] out_w,
	input logic               zero_norm
);
	`QN_ASSERT_NEVER(a_never_busy, busy)
	`QN_ASSERT_IMPLY(a_zero_outs, done && zero_norm, out_x == 0 && out_y == 0 && out_z == 0 && out_w == 0)
	`QN_ASSERT_IMPLY(a_range_xy, done, out_x <= 16384 && out_x >= -16384 && out_y <= 16384 && out_y >= -16384)
	`QN_ASSERT_IMPLY(a_range_zw, done, out_z <= 16384 && out_z >= -16384 && out_w <= 16384 && out_w >= -16384)
endmodule

bind quaternion_normalize qn_checker u_qn_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.busy      (busy),
	.done      (done),
	.out_x     (out_x),
	.out_y     (out_y),
	.out_z     (out_z),
	.out_w     (out_w),
	.zero_norm (zero_norm)
);

### sim/quaternion_normalize_test.sv
// Self-checking testbench for quaternion_normalize: directed and random quaternions,
// with an exact integer model of the rounded unit quaternion checked on every done.
// Depends on qn_pkg and the quaternion_normalize RTL.
`timescale 1ns / 1ps

module quaternion_normalize_test;
	import qn_pkg::*;

	typedef struct {
		logic signed [15:0] x, y, z, w;
	} quat_t;

	typedef struct {
		logic signed [15:0] x, y, z, w;
		logic               zn;
	} unit_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic signed [15:0] in_x = '0, in_y = '0, in_z = '0, in_w = '0;
	logic               done;
	logic signed [15:0] out_x, out_y, out_z, out_w;
	logic               zero_norm;

	quat_t pending_quats[$];
	unit_t expected_units[$];
	int    n_items = 0;
	int    n_sent = 0;
	int    gap = 0;
	int    idle_cycles = 0;
	int    n_errors = 0;

	quaternion_normalize dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [15:0] unit_component(logic signed [15:0] c, logic [33:0] s);
		logic [16:0]  mag;
		logic [127:0] rhs, lhs, a;
		logic [15:0]  m, t;
		mag = c[15] ? 17'(-{c[15], c}) : 17'(c);
		rhs = (128'(mag) * 128'(mag)) << (2 * FRAC_BITS + 2);
		m = '0;
		if (mag != 0) begin
			for (int b = FRAC_BITS; b >= 0; b--) begin
				t = m | (16'd1 << b);
				if (t <= (16'd1 << FRAC_BITS)) begin
					a = 128'(2 * t - 1) * 128'(2 * t - 1);
					lhs = a * 128'(s);
					if (lhs <= rhs)
						m = t;
				end
			end
		end
		return c[15] ? -m : m;
	endfunction

	function automatic unit_t normalise(quat_t q);
		unit_t       u;
		logic [33:0] s;
		s = 34'(34'(q.x) * 34'(q.x)) + 34'(34'(q.y) * 34'(q.y))
			+ 34'(34'(q.z) * 34'(q.z)) + 34'(34'(q.w) * 34'(q.w));
		u.zn = (s == 0);
		u.x = unit_component(q.x, s);
		u.y = unit_component(q.y, s);
		u.z = unit_component(q.z, s);
		u.w = unit_component(q.w, s);
		return u;
	endfunction

	function automatic logic signed [15:0] rand_comp(int mode);
		case (mode)
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 7)) - 16'sd4;
			2: return ($urandom_range(0, 1) ? 16'sh7fff : 16'sh8000) ^ 16'($urandom_range(0, 3));
			default: return 16'($urandom_range(0, 1) ? 0 : $urandom);
		endcase
	endfunction

	task automatic add_quat(logic signed [15:0] x, y, z, w);
		quat_t q;
		q.x = x; q.y = y; q.z = z; q.w = w;
		pending_quats.push_back(q);
		n_items++;
	endtask

	// driver
	always @(posedge clk) begin
		quat_t q;
		if (start && !busy) begin
			expected_units.push_back(normalise('{in_x, in_y, in_z, in_w}));
			n_sent++;
		end
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && busy) begin
			start <= 1'b1;
		end else if (gap > 0) begin
			start <= 1'b0;
			gap <= gap - 1;
		end else if (pending_quats.size() > 0) begin
			q = pending_quats.pop_front();
			in_x <= q.x; in_y <= q.y; in_z <= q.z; in_w <= q.w;
			start <= 1'b1;
			gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
		end else begin
			start <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		unit_t e;
		if (arst_n && done) begin
			if (expected_units.size() == 0) begin
				$error("unexpected transaction: out_x=%0d", out_x);
				n_errors++;
			end else begin
				e = expected_units.pop_front();
				if (out_x !== e.x) begin
					$error("out_x expected %0d actual %0d", e.x, out_x); n_errors++;
				end
				if (out_y !== e.y) begin
					$error("out_y expected %0d actual %0d", e.y, out_y); n_errors++;
				end
				if (out_z !== e.z) begin
					$error("out_z expected %0d actual %0d", e.z, out_z); n_errors++;
				end
				if (out_w !== e.w) begin
					$error("out_w expected %0d actual %0d", e.w, out_w); n_errors++;
				end
				if (zero_norm !== e.zn) begin
					$error("zero_norm expected %0d actual %0d", e.zn, zero_norm); n_errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= 2000) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		add_quat(0, 0, 0, 0);
		add_quat(-32768, -32768, -32768, -32768);
		add_quat(32767, 32767, 32767, 32767);
		add_quat(-32768, 0, 0, 0);
		add_quat(0, 32767, 0, 0);
		add_quat(0, 0, -32768, 0);
		add_quat(0, 0, 0, 1);
		add_quat(0, 0, 0, -1);
		add_quat(1, 1, 1, 1);
		add_quat(-1, 1, -1, 1);
		add_quat(3, 4, 0, 0);
		add_quat(-32768, 1, 0, 0);
		add_quat(32767, -32768, 1, -1);
		add_quat(1, 2, 2, 4);
		add_quat(0, 0, 0, 0);
		add_quat(-1, -1, 0, 0);
		for (int i = 0; i < 500; i++)
			add_quat(rand_comp($urandom_range(0, 3)), rand_comp($urandom_range(0, 3)),
				rand_comp($urandom_range(0, 3)), rand_comp($urandom_range(0, 3)));
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		wait (n_sent == n_items && expected_units.size() == 0);
		repeat (60) @(posedge clk);
		if (n_errors == 0 && expected_units.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
